// ----- rtl/core/gauge_response_telegram_checker_defines.svh -----
// assertion macros for the gauge response telegram checker
// expects clk and rst_n in the scope where a macro is used
`ifndef GAUGE_RESPONSE_TELEGRAM_CHECKER_DEFINES_SVH
`define GAUGE_RESPONSE_TELEGRAM_CHECKER_DEFINES_SVH

// same-cycle implication
`define GRTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GRTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/grtc_pkg.sv -----
// shared types, codes and constants for the gauge response telegram checker
// no dependencies
package grtc_pkg;

  localparam int unsigned MAX_FRAME     = 25;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [4:0]  GOOD_LENGTH   = 5'd20;
  localparam logic [7:0]  CHAR_ZERO     = 8'd48;
  localparam logic [7:0]  CHAR_NINE     = 8'd57;
  localparam logic [7:0]  CHAR_ONE      = 8'd49;
  localparam logic [7:0]  CHAR_SIX      = 8'd54;
  localparam logic [7:0]  CHAR_CR       = 8'h0D;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
  localparam logic [47:0] ZERO_CHARS    = {6{8'd48}};
  localparam logic [7:0]  EXP_ZERO      = 8'hEC;

  localparam logic [9:0]  ADDR_RESET    = 10'd1;
  localparam logic [9:0]  PARAM_RESET   = 10'd740;
  localparam logic [15:0] LIMIT_RESET   = 16'd5;

  localparam logic [1:0]  ACT_BYTE      = 2'd0;
  localparam logic [1:0]  ACT_TIMEOUT   = 2'd1;
  localparam logic [1:0]  ACT_CLEAR     = 2'd2;

  localparam logic [1:0]  REG_ADDR      = 2'd0;
  localparam logic [1:0]  REG_PARAM     = 2'd1;
  localparam logic [1:0]  REG_LIMIT     = 2'd2;

  localparam logic [2:0]  ST_OK           = 3'd0;
  localparam logic [2:0]  ST_NO_RESPONSE  = 3'd1;
  localparam logic [2:0]  ST_WRONG_SIZE   = 3'd2;
  localparam logic [2:0]  ST_BAD_FORMAT   = 3'd3;
  localparam logic [2:0]  ST_BAD_CHECKSUM = 3'd4;

  typedef struct packed {
    logic        is_clear;
    logic [2:0]  status;
    logic [47:0] chars;
  } event_t;

  // three ascii digits of a value, all zero bytes when above 999
  function automatic logic [23:0] dec_chars(input logic [9:0] v);
    logic [15:0] p1;
    logic [3:0]  h;
    logic [9:0]  r10;
    logic [14:0] p2;
    logic [3:0]  t;
    logic [6:0]  o;
    p1  = 16'(v) * 16'd41;
    h   = p1[15:12];
    r10 = v - (10'(h) * 10'd100);
    p2  = 15'(r10[6:0]) * 15'd205;
    t   = p2[14:11];
    o   = r10[6:0] - (7'(t) * 7'd10);
    if (v > 10'd999) begin
      dec_chars = 24'd0;
    end else begin
      dec_chars = {CHAR_ZERO + 8'(h), CHAR_ZERO + 8'(t), CHAR_ZERO + 8'(o[3:0])};
    end
  endfunction

endpackage

// ----- rtl/core/grtc_front.sv -----
// front end: takes received bytes, timeouts and clears, tracks the frame and judges it on its end
// depends on grtc_pkg
module grtc_front import grtc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_rx_byte,
  input  logic [23:0] addr_chars,
  input  logic [23:0] param_chars,
  input  logic        q_full,
  output logic        push_valid,
  output event_t      push_evt
);

  logic [4:0] cnt_r, cnt_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       hdr_ok_r, hdr_ok_nxt;
  logic       data_bad_r, data_bad_nxt;
  logic [7:0] data_r [6];
  logic [7:0] data_nxt [6];
  logic [9:0] check_r, check_nxt;
  logic       check_bad_r, check_bad_nxt;

  logic        accept;
  logic [4:0]  cnt_inc;
  logic [7:0]  exp_char;
  logic        is_digit;
  logic        frame_end;
  logic [2:0]  verdict;
  logic [13:0] check_prod;
  logic [2:0]  data_idx;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign cnt_inc  = cnt_r + 5'd1;
  assign is_digit = (in_rx_byte >= CHAR_ZERO) && (in_rx_byte <= CHAR_NINE);
  assign check_prod = (14'(check_r) * 14'd10) + 14'(in_rx_byte[3:0]);
  assign data_idx = 3'(cnt_r - 5'd10);

  always_comb begin
    case (cnt_r)
      5'd0:    exp_char = addr_chars[23:16];
      5'd1:    exp_char = addr_chars[15:8];
      5'd2:    exp_char = addr_chars[7:0];
      5'd3:    exp_char = CHAR_ONE;
      5'd4:    exp_char = CHAR_ZERO;
      5'd5:    exp_char = param_chars[23:16];
      5'd6:    exp_char = param_chars[15:8];
      5'd7:    exp_char = param_chars[7:0];
      5'd8:    exp_char = CHAR_ZERO;
      default: exp_char = CHAR_SIX;
    endcase
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    hdr_ok_nxt    = hdr_ok_r;
    data_bad_nxt  = data_bad_r;
    data_nxt      = data_r;
    check_nxt     = check_r;
    check_bad_nxt = check_bad_r;
    frame_end     = 1'b0;
    verdict       = ST_OK;
    push_valid    = 1'b0;
    push_evt      = '{is_clear: 1'b0, status: ST_OK, chars: ZERO_CHARS};

    if (accept) begin
      case (in_action)
        ACT_TIMEOUT: begin
          push_valid      = 1'b1;
          push_evt.status = ST_NO_RESPONSE;
          cnt_nxt         = '0;
          sum_nxt         = '0;
          hdr_ok_nxt      = 1'b1;
          data_bad_nxt    = 1'b0;
          check_nxt       = '0;
          check_bad_nxt   = 1'b0;
        end
        ACT_CLEAR: begin
          push_valid        = 1'b1;
          push_evt.is_clear = 1'b1;
        end
        ACT_BYTE: begin
          cnt_nxt = cnt_inc;
          if (in_rx_byte != CHAR_CR) begin
            if (cnt_r < 5'd16) begin
              sum_nxt = sum_r + in_rx_byte;
            end
            if (cnt_r < 5'd10) begin
              if (in_rx_byte != exp_char) begin
                hdr_ok_nxt = 1'b0;
              end
            end else if (cnt_r < 5'd16) begin
              data_nxt[data_idx] = in_rx_byte;
              if (!is_digit) begin
                data_bad_nxt = 1'b1;
              end
            end else if (cnt_r < 5'd19) begin
              if (is_digit) begin
                check_nxt = check_prod[9:0];
              end else begin
                check_bad_nxt = 1'b1;
              end
            end
            frame_end = (cnt_inc >= 5'(MAX_FRAME));
          end else begin
            frame_end = 1'b1;
          end

          if (cnt_nxt != GOOD_LENGTH) begin
            verdict = ST_WRONG_SIZE;
          end else if (!hdr_ok_nxt || data_bad_nxt) begin
            verdict = ST_BAD_FORMAT;
          end else if (check_bad_nxt || (check_nxt != {2'b00, sum_nxt})) begin
            verdict = ST_BAD_CHECKSUM;
          end else begin
            verdict = ST_OK;
          end

          if (frame_end) begin
            push_valid      = 1'b1;
            push_evt.status = verdict;
            push_evt.chars  = {data_nxt[0], data_nxt[1], data_nxt[2],
                               data_nxt[3], data_nxt[4], data_nxt[5]};
            cnt_nxt         = '0;
            sum_nxt         = '0;
            hdr_ok_nxt      = 1'b1;
            data_bad_nxt    = 1'b0;
            check_nxt       = '0;
            check_bad_nxt   = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sum_r       <= '0;
      hdr_ok_r    <= 1'b1;
      data_bad_r  <= 1'b0;
      check_r     <= '0;
      check_bad_r <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        data_r[i] <= CHAR_ZERO;
      end
    end else begin
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      hdr_ok_r    <= hdr_ok_nxt;
      data_bad_r  <= data_bad_nxt;
      check_r     <= check_nxt;
      check_bad_r <= check_bad_nxt;
      data_r      <= data_nxt;
    end
  end

endmodule

// ----- rtl/core/grtc_queue.sv -----
// short transaction queue between the front end and the back end
// depends on grtc_pkg
module grtc_queue import grtc_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  event_t push_evt,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output event_t head
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  event_t        mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_evt;
    end
  end

endmodule

// ----- rtl/core/grtc_back.sv -----
// back end: error counters, value decode and the result register
// depends on grtc_pkg
module grtc_back import grtc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        not_empty,
  input  event_t      head,
  output logic        pop,
  input  logic [15:0] report_limit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [47:0] out_data_chars,
  output logic [13:0] out_mantissa,
  output logic [7:0]  out_exponent,
  output logic        out_report_error,
  output logic [15:0] out_error_total,
  output logic [15:0] out_consecutive_errors
);

  logic        valid_r, valid_nxt;
  logic [15:0] total_r, total_nxt;
  logic [15:0] run_r, run_nxt;
  logic [2:0]  status_r;
  logic [47:0] chars_r;
  logic [13:0] mant_r;
  logic [7:0]  expo_r;
  logic        report_r;
  logic [15:0] total_out_r;
  logic [15:0] run_out_r;

  logic        load_ok, load;
  logic        is_err;
  logic [47:0] chars;
  logic [3:0]  dg [6];
  logic [13:0] mant;
  logic [7:0]  expo;
  logic        report;

  assign load_ok = !valid_r || !out_stall;
  assign pop     = not_empty && (head.is_clear || load_ok);
  assign load    = not_empty && !head.is_clear && load_ok;
  assign is_err  = (head.status != ST_OK);
  assign chars   = is_err ? ZERO_CHARS : head.chars;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      dg[i] = chars[43 - 8*i -: 4];
    end
    mant = (14'(dg[0]) * 14'd1000) + (14'(dg[1]) * 14'd100)
         + (14'(dg[2]) * 14'd10) + 14'(dg[3]);
    expo = (8'(dg[4]) * 8'd10) + 8'(dg[5]) - 8'd20;
  end

  always_comb begin
    total_nxt = total_r;
    run_nxt   = run_r;
    valid_nxt = valid_r && out_stall;
    report    = 1'b0;
    if (pop && head.is_clear) begin
      total_nxt = '0;
    end else if (load) begin
      valid_nxt = 1'b1;
      if (is_err) begin
        total_nxt = (total_r == COUNT_MAX) ? total_r : total_r + 16'd1;
        run_nxt   = (run_r == COUNT_MAX) ? run_r : run_r + 16'd1;
        report    = (run_nxt < report_limit);
      end else begin
        run_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      total_r <= '0;
      run_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      total_r <= total_nxt;
      run_r   <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r    <= head.status;
      chars_r     <= chars;
      mant_r      <= mant;
      expo_r      <= expo;
      report_r    <= report;
      total_out_r <= total_nxt;
      run_out_r   <= run_nxt;
    end
  end

  assign out_valid              = valid_r;
  assign out_status             = status_r;
  assign out_data_chars         = chars_r;
  assign out_mantissa           = mant_r;
  assign out_exponent           = expo_r;
  assign out_report_error       = report_r;
  assign out_error_total        = total_out_r;
  assign out_consecutive_errors = run_out_r;

endmodule

// ----- rtl/core/gauge_response_telegram_checker.sv -----
// gauge reply checker top level: config registers, front end, queue, back end
// a result reaches out_valid from the frame's last byte via the queue memory and then the result register
// throughput: one transaction per cycle while in_stall is low, set by the single-byte front end
// in_stall rises only when the queue is full behind a stalled result
// reset: synchronous active low, clears frame state and counters, restores
// address 1, parameter 740 and report limit 5; no clearing pass is needed
`include "gauge_response_telegram_checker_defines.svh"
module gauge_response_telegram_checker import grtc_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [47:0] out_data_chars,
  output logic [13:0] out_mantissa,
  output logic [7:0]  out_exponent,
  output logic        out_report_error,
  output logic [15:0] out_error_total,
  output logic [15:0] out_consecutive_errors
);

  logic [23:0] addr_chars_r, addr_chars_nxt;
  logic [23:0] param_chars_r, param_chars_nxt;
  logic [15:0] limit_r, limit_nxt;

  logic   q_full, q_not_empty, q_pop, push_valid;
  event_t push_evt, q_head;

  always_comb begin
    addr_chars_nxt  = addr_chars_r;
    param_chars_nxt = param_chars_r;
    limit_nxt       = limit_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ADDR:  addr_chars_nxt  = dec_chars(cfg_wdata[9:0]);
        REG_PARAM: param_chars_nxt = dec_chars(cfg_wdata[9:0]);
        REG_LIMIT: limit_nxt       = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_chars_r  <= dec_chars(ADDR_RESET);
      param_chars_r <= dec_chars(PARAM_RESET);
      limit_r       <= LIMIT_RESET;
    end else begin
      addr_chars_r  <= addr_chars_nxt;
      param_chars_r <= param_chars_nxt;
      limit_r       <= limit_nxt;
    end
  end

  grtc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_action   (in_action),
    .in_rx_byte  (in_rx_byte),
    .addr_chars  (addr_chars_r),
    .param_chars (param_chars_r),
    .q_full      (q_full),
    .push_valid  (push_valid),
    .push_evt    (push_evt)
  );

  grtc_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_evt  (push_evt),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  grtc_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .not_empty              (q_not_empty),
    .head                   (q_head),
    .pop                    (q_pop),
    .report_limit           (limit_r),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_status             (out_status),
    .out_data_chars         (out_data_chars),
    .out_mantissa           (out_mantissa),
    .out_exponent           (out_exponent),
    .out_report_error       (out_report_error),
    .out_error_total        (out_error_total),
    .out_consecutive_errors (out_consecutive_errors)
  );

  `GRTC_ASSERT_NOW(a_ok_clears_run, out_valid && (out_status == ST_OK), !out_report_error && (out_consecutive_errors == 16'd0), "good reply did not clear error run")
  `GRTC_ASSERT_NOW(a_err_zero_data, out_valid && (out_status != ST_OK), (out_data_chars == ZERO_CHARS) && (out_mantissa == 14'd0) && (out_exponent == EXP_ZERO), "error reply carries data")
  `GRTC_ASSERT_NOW(a_report_limit, out_valid && (out_consecutive_errors >= limit_r), !out_report_error, "error flagged past report limit")
  `GRTC_ASSERT_NEXT(a_stall_drains, in_stall && !out_stall, !in_stall, "queue did not drain while output moves")

endmodule
